### design/nsfe_pkg.sv
`default_nettype none

package nsfe_pkg;

  // Byte codes that steer the parser.
  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_C      = 8'h43;
  localparam logic [7:0] CHAR_S      = 8'h53;
  localparam logic [7:0] CHAR_A      = 8'h41;

  // Sentence kinds.
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_RMC  = 2'd1;
  localparam logic [1:0] KIND_GGA  = 2'd2;
  localparam logic [1:0] KIND_SKIP = 2'd3;

  // Comma counter limits.
  localparam int unsigned COMMA_W = 5;
  localparam logic [COMMA_W-1:0] COMMA_MAX       = 5'd31;
  localparam logic [COMMA_W-1:0] COMMA_AFTER_NUL = 5'd25;

  // Field codes of the captured fields.
  localparam logic [2:0] FLD_TIME = 3'd0;
  localparam logic [2:0] FLD_LAT  = 3'd1;
  localparam logic [2:0] FLD_LON  = 3'd2;
  localparam logic [2:0] FLD_SATS = 3'd3;
  localparam logic [2:0] FLD_ALT  = 3'd4;
  localparam logic [2:0] FLD_SPD  = 3'd5;
  localparam logic [2:0] FLD_CRS  = 3'd6;

  // One result item plus its valid flag.
  typedef struct packed {
    logic       valid;
    logic [2:0] field_code;
    logic [3:0] char_position;
    logic [7:0] char_value;
  } result_t;

  // Field selection: bit 3 says the field is captured, bits 2:0 give its code.
  function automatic logic [3:0] select_field(input logic [1:0] kind,
                                              input logic [COMMA_W-1:0] commas);
    logic [3:0] sel;
    sel = 4'b0000;
    if (kind == KIND_GGA) begin
      unique case (commas)
        5'd1:    sel = {1'b1, FLD_TIME};
        5'd2:    sel = {1'b1, FLD_LAT};
        5'd4:    sel = {1'b1, FLD_LON};
        5'd7:    sel = {1'b1, FLD_SATS};
        5'd9:    sel = {1'b1, FLD_ALT};
        default: sel = 4'b0000;
      endcase
    end else if (kind == KIND_RMC) begin
      unique case (commas)
        5'd7:    sel = {1'b1, FLD_SPD};
        5'd8:    sel = {1'b1, FLD_CRS};
        default: sel = 4'b0000;
      endcase
    end
    return sel;
  endfunction

endpackage

`default_nettype wire

### design/nsfe_parser.sv
`default_nettype none

module nsfe_parser #(
  parameter int unsigned MAX_FIELD_LEN = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [7:0]        rx_char,
  output nsfe_pkg::result_t      result
);

  localparam int unsigned POS_W = $clog2(MAX_FIELD_LEN + 1);
  localparam int unsigned EXT_W = (POS_W > 4) ? POS_W : 4;

  logic [nsfe_pkg::COMMA_W-1:0] comma_count_r, comma_count_nxt;
  logic [1:0]                   kind_r, kind_nxt;
  logic [POS_W-1:0]             field_pos_r, field_pos_nxt;
  logic [3:0]                   sel;
  logic [EXT_W-1:0]             pos_ext;
  logic                         room;

  assign sel     = nsfe_pkg::select_field(kind_r, comma_count_r);
  assign pos_ext = EXT_W'(field_pos_r);
  assign room    = (field_pos_r < POS_W'(MAX_FIELD_LEN));

  // Decode one byte into the next state and an optional result item.
  always_comb begin
    comma_count_nxt      = comma_count_r;
    kind_nxt             = kind_r;
    field_pos_nxt        = field_pos_r;
    result.valid         = 1'b0;
    result.field_code    = sel[2:0];
    result.char_position = pos_ext[3:0];
    result.char_value    = rx_char;
    if (rx_char == nsfe_pkg::CHAR_NUL) begin
      comma_count_nxt = nsfe_pkg::COMMA_AFTER_NUL;
      kind_nxt        = nsfe_pkg::KIND_NONE;
    end else if (rx_char == nsfe_pkg::CHAR_DOLLAR) begin
      comma_count_nxt = '0;
      kind_nxt        = nsfe_pkg::KIND_NONE;
    end else if (rx_char == nsfe_pkg::CHAR_COMMA) begin
      if (comma_count_r != nsfe_pkg::COMMA_MAX) begin
        comma_count_nxt = comma_count_r + 1'b1;
      end
      field_pos_nxt = '0;
    end else if (comma_count_r == '0) begin
      // Sentence identifier: classify by its letters.
      if (rx_char == nsfe_pkg::CHAR_C) begin
        kind_nxt = nsfe_pkg::KIND_RMC;
      end else if (rx_char == nsfe_pkg::CHAR_S) begin
        kind_nxt = nsfe_pkg::KIND_SKIP;
      end else if (rx_char == nsfe_pkg::CHAR_A && kind_r != nsfe_pkg::KIND_SKIP) begin
        kind_nxt = nsfe_pkg::KIND_GGA;
      end
    end else if (sel[3] && room) begin
      result.valid  = 1'b1;
      field_pos_nxt = field_pos_r + 1'b1;
    end
    result.valid = result.valid & step;
  end

  // Parser state advances on every accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comma_count_r <= '0;
      kind_r        <= nsfe_pkg::KIND_NONE;
      field_pos_r   <= '0;
    end else if (step) begin
      comma_count_r <= comma_count_nxt;
      kind_r        <= kind_nxt;
      field_pos_r   <= field_pos_nxt;
    end
  end

endmodule

`default_nettype wire

### design/nmea_sentence_field_extractor_unit.sv
`default_nettype none

// Channel   Direction  tdata fields (low bit up)                     Items
// in_*      input      rx_char[7:0]                                  one byte each
// out_*     output     field_code[2:0], char_position[6:3],          zero or one
//                      char_value[14:7], zero[15]                    per input item
//
// One item is accepted per cycle while the skid entry is empty; its result is registered.
// The parser state and the decode sit between the input handshake and an
// output register backed by one skid entry, so input stalls only when both hold.
// Reset is synchronous and active low; it clears the parser state and both
// valid flags.
module nmea_sentence_field_extractor_unit #(
  parameter int unsigned MAX_FIELD_LEN = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // rx_char[7:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // field_code[2:0], char_position[6:3],
                                       // char_value[14:7], zero[15]
);

  nsfe_pkg::result_t res;
  nsfe_pkg::result_t out_r, skid_r;
  logic              out_valid_r, skid_valid_r;
  logic              accept, pop;

  assign in_tready = ~skid_valid_r;
  assign accept    = in_tvalid & in_tready;
  assign pop       = out_valid_r & out_tready;

  nsfe_parser #(
    .MAX_FIELD_LEN(MAX_FIELD_LEN)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (accept),
    .rx_char (in_tdata),
    .result  (res)
  );

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (res.valid) begin
      if (!out_valid_r || pop) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r.char_value, out_r.char_position, out_r.field_code};

endmodule

`default_nettype wire

### bench/nmea_sentence_field_extractor_unit_tb.sv
`default_nettype none

module nmea_sentence_field_extractor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_FIELD_LEN = 16;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SENT_TARGET   = 470;
  localparam int unsigned DRAIN_CYCLES  = 8;

  // One captured character as the block reports it.
  typedef struct packed {
    logic [2:0] code;
    logic [3:0] pos;
    logic [7:0] value;
  } gps_char_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  // Parser state as this bench tracks it.
  logic [nsfe_pkg::COMMA_W-1:0] trk_commas = '0;
  logic [1:0]                   trk_kind   = nsfe_pkg::KIND_NONE;
  logic [4:0]                   trk_pos    = '0;

  gps_char_t   pending_chars[$];
  int unsigned error_count  = 0;
  int unsigned sent_items   = 0;
  int unsigned cycle_count  = 0;
  bit          src_idle_en  = 1'b1;
  bit          sink_idle_en = 1'b1;

  nmea_sentence_field_extractor_unit #(
    .MAX_FIELD_LEN(MAX_FIELD_LEN)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // rx_char[7:0]
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)   // field_code[2:0], char_position[6:3], char_value[14:7]
  );

  always #5 clk = ~clk;

  // Run guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Advances the tracked parser by one byte and queues the character it
  // captures.
  function automatic void track_gps_byte(input logic [7:0] b);
    logic [2:0] code;
    bit         wanted;
    gps_char_t  item;
    code   = nsfe_pkg::FLD_TIME;
    wanted = 1'b0;
    if (b == nsfe_pkg::CHAR_NUL) begin
      trk_commas = nsfe_pkg::COMMA_AFTER_NUL;
      trk_kind   = nsfe_pkg::KIND_NONE;
      return;
    end
    if (b == nsfe_pkg::CHAR_DOLLAR) begin
      trk_commas = '0;
      trk_kind   = nsfe_pkg::KIND_NONE;
      return;
    end
    if (b == nsfe_pkg::CHAR_COMMA) begin
      if (trk_commas != nsfe_pkg::COMMA_MAX) trk_commas = trk_commas + 1'b1;
      trk_pos = '0;
      return;
    end

    // Sentence identifier, before the first comma.
    if (trk_commas == 0) begin
      if (b == nsfe_pkg::CHAR_C) begin
        trk_kind = nsfe_pkg::KIND_RMC;
        return;
      end
      if (b == nsfe_pkg::CHAR_S) begin
        trk_kind = nsfe_pkg::KIND_SKIP;
        return;
      end
      if (b == nsfe_pkg::CHAR_A) begin
        if (trk_kind != nsfe_pkg::KIND_SKIP) trk_kind = nsfe_pkg::KIND_GGA;
        return;
      end
      return;
    end

    // Which field of which sentence this character belongs to.
    if (trk_kind == nsfe_pkg::KIND_GGA) begin
      wanted = 1'b1;
      case (trk_commas)
        5'd1:    code = nsfe_pkg::FLD_TIME;
        5'd2:    code = nsfe_pkg::FLD_LAT;
        5'd4:    code = nsfe_pkg::FLD_LON;
        5'd7:    code = nsfe_pkg::FLD_SATS;
        5'd9:    code = nsfe_pkg::FLD_ALT;
        default: wanted = 1'b0;
      endcase
    end else if (trk_kind == nsfe_pkg::KIND_RMC) begin
      wanted = 1'b1;
      case (trk_commas)
        5'd7:    code = nsfe_pkg::FLD_SPD;
        5'd8:    code = nsfe_pkg::FLD_CRS;
        default: wanted = 1'b0;
      endcase
    end
    if (!wanted || trk_pos >= MAX_FIELD_LEN) return;

    item.code  = code;
    item.pos   = trk_pos[3:0];
    item.value = b;
    pending_chars.push_back(item);
    trk_pos = trk_pos + 1'b1;
  endfunction

  // Offers one byte, with an occasional idle burst ahead of it. Called and
  // returns at a falling edge.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    track_gps_byte(b);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Lowers valid and holds off until every queued character has come out.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_chars.size() != 0) @(negedge clk);
  endtask

  // Field content: mostly printable text, sometimes any byte at all.
  function automatic logic [7:0] field_byte();
    logic [7:0] b;
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    b = 8'($urandom_range(8'h21, 8'h7E));
    if (b == nsfe_pkg::CHAR_DOLLAR || b == nsfe_pkg::CHAR_COMMA) b = "0";
    return b;
  endfunction

  // One sentence with random identifier, field count and field lengths; a few
  // come out broken by a lost dollar sign or a stray NUL.
  task automatic send_random_sentence();
    int    sel;
    int    nfields;
    int    flen;
    string ident;
    sel = $urandom_range(0, 9);
    if (sel <= 3)      ident = "GPGGA";
    else if (sel <= 6) ident = "GPRMC";
    else if (sel == 7) ident = "GPGSA";
    else if (sel == 8) ident = "GPGSV";
    else begin
      ident = "";
      repeat ($urandom_range(1, 6)) ident = {ident, string'(8'($urandom_range(8'h41, 8'h5A)))};
    end
    if ($urandom_range(0, 9) != 0) send_byte(nsfe_pkg::CHAR_DOLLAR);
    send_text(ident);
    nfields = ($urandom_range(0, 15) == 0) ? $urandom_range(26, 36) : $urandom_range(0, 14);
    for (int f = 0; f < nfields; f++) begin
      send_byte(nsfe_pkg::CHAR_COMMA);
      flen = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 9);
      repeat (flen) send_byte(field_byte());
      if ($urandom_range(0, 49) == 0) send_byte(nsfe_pkg::CHAR_NUL);
    end
  endtask

  // NUL, dollar sign and comma handling, including comma saturation.
  task automatic test_control_bytes();
    send_text("$A,9,");
    send_byte(8'hFF);
    send_byte(nsfe_pkg::CHAR_NUL);
    send_byte(8'h80);
    repeat (7) send_byte(nsfe_pkg::CHAR_COMMA);
    send_byte("5");
  endtask

  // Identifier letters: skip wins over a later A, A after C gives GGA.
  task automatic test_identifier_kinds();
    send_text("$SA,1");
    send_text("$CA,2");
    send_text("$AC,3");
  endtask

  // Sender holds off until the block has emptied, then resumes.
  task automatic test_drain_pause();
    send_text("$GPGGA,123519,4807.038");
    wait_for_drain();
    send_text(",N,01131.000,E,1,08,0.9,545.4,M");
  endtask

  task automatic test_random_sentences();
    while (sent_items < SENT_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        src_idle_en  = ($urandom_range(0, 3) != 0);
        sink_idle_en = ($urandom_range(0, 3) != 0);
      end
      send_random_sentence();
    end
  endtask

  // Final stretch at full rate on both sides.
  task automatic test_unstalled_tail();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (2) send_random_sentence();
  endtask

  // Result receiver with bursts of back-pressure.
  initial begin : drive_out_ready
    forever begin
      @(negedge clk);
      if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each delivered item with the oldest expected character.
  always @(posedge clk) begin : check_results
    gps_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected item 0x%04h", out_tdata));
      end else begin
        want = pending_chars.pop_front();
        if (out_tdata[2:0] !== want.code)
          report_mismatch($sformatf("field_code %0d, expected %0d", out_tdata[2:0], want.code));
        if (out_tdata[6:3] !== want.pos)
          report_mismatch($sformatf("char_position %0d, expected %0d", out_tdata[6:3],
                                    want.pos));
        if (out_tdata[14:7] !== want.value)
          report_mismatch($sformatf("char_value 0x%02h, expected 0x%02h", out_tdata[14:7],
                                    want.value));
      end
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_control_bytes();
    test_identifier_kinds();
    test_drain_pause();
    test_random_sentences();
    test_unstalled_tail();

    // Let the last items come out, then allow for the pipeline latency.
    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

### nmea_sentence_field_extractor_unit.f
design/nsfe_pkg.sv
design/nsfe_parser.sv
design/nmea_sentence_field_extractor_unit.sv
bench/nmea_sentence_field_extractor_unit_tb.sv
